// File: design/boxavg_pkg.sv
// Package for the box-average downsampler.
// Shared types and constants: configuration register map, block info beat.
// No dependencies.
package boxavg_pkg;

    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 13;
    localparam int FACTOR_REG_W  = 5;
    localparam int SIZE_REG_W    = 13;
    localparam int COORD_W       = 12;
    localparam int ROW_W         = 12;
    localparam int MAX_HEIGHT    = 4096;
    localparam int PLANES        = 3;

    localparam logic [FACTOR_REG_W-1:0] FACTOR_RESET = 5'd2;
    localparam logic [SIZE_REG_W-1:0]   WIDTH_RESET  = 13'd4096;
    localparam logic [SIZE_REG_W-1:0]   HEIGHT_RESET = 13'd4096;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FACTOR = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2,
        REG_COLOUR = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic               first;
        logic               last;
        logic               frame_last;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } blk_info_t;

endpackage

// File: design/box_average_downsampler.sv
// Top level of the box-average image downsampler.
// Depends on boxavg_pkg, boxavg_ctrl, boxavg_accum, boxavg_div, boxavg_ram.
//
// Usage:
//   Pixels enter in raster order on the in_valid / in_stall channel, one beat
//   per pixel with red, green and blue samples. Each factor-by-factor block is
//   summed in a column-sum RAM (one entry per block column); on the block's
//   bottom-right pixel the block mean leaves on the out_valid / out_stall
//   channel with its column, row and an end-of-frame mark. Partial blocks at
//   the right and bottom edges produce nothing.
//   Throughput: one pixel per cycle while in_stall is low. The RAM
//   read-modify-write completes in one stage with a bypass for back-to-back
//   beats to the same block column. A block's result passes one accumulate
//   stage and one divider stage per quotient bit after its last pixel is taken.
//   Stall: out_stall holds the result; the divider stages fill up behind it,
//   and in_stall rises only once a block-completing pixel cannot enter it.
//   A factor write raises in_stall while the block row is rebuilt.
//   Reset: counters clear to the frame start and registers take defaults
//   (factor 2, 4096 x 4096, mono). The RAM is not cleared; each block's first
//   pixel overwrites its entry. Write configuration only while idle.
module box_average_downsampler #(
    parameter int MAX_WIDTH   = 4096,
    parameter int MAX_FACTOR  = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [boxavg_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [boxavg_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [SAMPLE_BITS-1:0]              red_sample,
    input  logic [SAMPLE_BITS-1:0]              green_sample,
    input  logic [SAMPLE_BITS-1:0]              blue_sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [SAMPLE_BITS-1:0]              average_sample,
    output logic [boxavg_pkg::COORD_W-1:0]      out_column,
    output logic [boxavg_pkg::COORD_W-1:0]      out_row,
    output logic                                frame_last
);

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int OW    = $clog2(MAX_FACTOR);
    localparam int ACC_W = SAMPLE_BITS + 2 + 2 * OW;
    localparam int DIV_W = $clog2(boxavg_pkg::PLANES * MAX_FACTOR * MAX_FACTOR + 1);

    logic                  accept;
    logic                  blk_valid;
    logic [AW-1:0]         blk_addr;
    logic [SAMPLE_BITS+1:0] blk_sample;
    boxavg_pkg::blk_info_t blk_info;
    logic [DIV_W-1:0]      div_value;
    logic                  row_busy;
    logic                  acc_ready;
    logic                  sum_valid;
    logic [ACC_W-1:0]      sum_value;
    boxavg_pkg::blk_info_t sum_info;
    logic                  div_ready;
    boxavg_pkg::blk_info_t res_info;

    assign in_stall = !acc_ready || row_busy;
    assign accept   = in_valid && !in_stall;

    boxavg_ctrl #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_FACTOR  (MAX_FACTOR),
        .SAMPLE_BITS (SAMPLE_BITS),
        .DIV_W       (DIV_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .red_sample   (red_sample),
        .green_sample (green_sample),
        .blue_sample  (blue_sample),
        .blk_valid    (blk_valid),
        .blk_addr     (blk_addr),
        .blk_sample   (blk_sample),
        .blk_info     (blk_info),
        .div_value    (div_value),
        .row_busy     (row_busy)
    );

    boxavg_accum #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACC_W       (ACC_W)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .blk_valid  (blk_valid),
        .blk_addr   (blk_addr),
        .blk_sample (blk_sample),
        .blk_info   (blk_info),
        .ready      (acc_ready),
        .sum_valid  (sum_valid),
        .sum_value  (sum_value),
        .sum_info   (sum_info),
        .sum_ready  (div_ready)
    );

    boxavg_div #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACC_W       (ACC_W),
        .DIV_W       (DIV_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sum_valid),
        .in_ready  (div_ready),
        .in_value  (sum_value),
        .in_info   (sum_info),
        .divisor   (div_value),
        .out_valid (out_valid),
        .out_ready (!out_stall),
        .quotient  (average_sample),
        .out_info  (res_info)
    );

    assign out_column = res_info.col;
    assign out_row    = res_info.row;
    assign frame_last = res_info.frame_last;

    // Input backs up only when the divider entry is blocked or the row rebuilds.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (!div_ready || row_busy))
        else $error("in_stall raised while the divider can take a sum");

    // A finished block sum only leaves the accumulator into a free divider stage.
    a_sum_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        sum_valid |-> div_ready)
        else $error("block sum dropped at the divider entry");

    // The divisor register never holds zero.
    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_value != '0)
        else $error("divisor is zero");

endmodule

// File: design/boxavg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module boxavg_ram #(
    parameter int DATA_W = 26,
    parameter int DEPTH  = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/boxavg_ctrl.sv
// Configuration registers, raster position counters and block decode.
// Depends on boxavg_pkg.
module boxavg_ctrl #(
    parameter int MAX_WIDTH   = 4096,
    parameter int MAX_FACTOR  = 16,
    parameter int SAMPLE_BITS = 16,
    parameter int DIV_W       = 10
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [boxavg_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [boxavg_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                  accept,
    input  logic [SAMPLE_BITS-1:0]                red_sample,
    input  logic [SAMPLE_BITS-1:0]                green_sample,
    input  logic [SAMPLE_BITS-1:0]                blue_sample,
    output logic                                  blk_valid,
    output logic [$clog2(MAX_WIDTH)-1:0]          blk_addr,
    output logic [SAMPLE_BITS+1:0]                blk_sample,
    output boxavg_pkg::blk_info_t                 blk_info,
    output logic [DIV_W-1:0]                      div_value,
    output logic                                  row_busy
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int OW  = $clog2(MAX_FACTOR);
    localparam int FW  = $clog2(MAX_FACTOR + 1);
    localparam int FXW = (FW > boxavg_pkg::FACTOR_REG_W) ? FW : boxavg_pkg::FACTOR_REG_W;
    localparam int WXW = (WW > boxavg_pkg::SIZE_REG_W) ? WW : boxavg_pkg::SIZE_REG_W;
    localparam int HW  = boxavg_pkg::SIZE_REG_W;
    localparam int RW  = boxavg_pkg::ROW_W;
    localparam int CEW = AW + FW + 1;
    localparam int REW = RW + FW + 1;
    localparam int SW  = SAMPLE_BITS + 2;
    localparam int CW  = $clog2(RW);
    localparam int PW  = OW + 1;

    logic [boxavg_pkg::FACTOR_REG_W-1:0] factor_reg;
    logic [boxavg_pkg::SIZE_REG_W-1:0]   width_reg;
    logic [boxavg_pkg::SIZE_REG_W-1:0]   height_reg;
    logic                                colour_reg;
    logic [DIV_W-1:0]                    div_reg;
    logic [DIV_W-1:0]                    div_next;

    logic [AW-1:0] pcol_reg;
    logic [RW-1:0] prow_reg;
    logic [OW-1:0] wcol_reg;
    logic [OW-1:0] wrow_reg;
    logic [AW-1:0] bcol_reg;
    logic [RW-1:0] brow_reg;
    logic [OW-1:0] rrow_reg;
    logic          row_busy_reg;
    logic [CW-1:0] row_bit_reg;

    logic [FXW-1:0]  factor_x;
    logic [WXW-1:0]  width_x;
    logic [FW-1:0]   d;
    logic [WW-1:0]   w;
    logic [HW-1:0]   h;
    logic [2*FW-1:0] dd;

    logic [CEW-1:0] col_end;
    logic [REW-1:0] row_end;
    logic           col_fit;
    logic           row_fit;
    logic           col_final;
    logic           row_final;
    logic           col_wrap;
    logic           row_wrap;
    logic           wcol_wrap;
    logic           wrow_wrap;
    logic           rrow_wrap;
    logic           factor_write;
    logic [PW-1:0]  row_partial;
    logic           row_take;
    logic [OW-1:0]  row_rem;

    // Clamp the raw register values into their legal ranges.
    assign factor_x = FXW'(factor_reg);
    assign width_x  = WXW'(width_reg);
    assign d = (factor_x == '0) ? FW'(1) :
               (factor_x > FXW'(MAX_FACTOR)) ? FW'(MAX_FACTOR) : FW'(factor_x);
    assign w = (width_x == '0) ? WW'(1) :
               (width_x > WXW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(width_x);
    assign h = (height_reg == '0) ? HW'(1) :
               (height_reg > HW'(boxavg_pkg::MAX_HEIGHT)) ? HW'(boxavg_pkg::MAX_HEIGHT)
                                                          : height_reg;

    // A block fits when its far edge stays inside the image.
    assign col_end   = (CEW'(bcol_reg) + CEW'(1)) * CEW'(d);
    assign row_end   = (REW'(brow_reg) + REW'(1)) * REW'(d);
    assign col_fit   = col_end <= CEW'(w);
    assign row_fit   = row_end <= REW'(h);
    assign col_final = (col_end + CEW'(d)) > CEW'(w);
    assign row_final = (row_end + REW'(d)) > REW'(h);

    assign col_wrap  = (WW'(pcol_reg) + WW'(1)) >= w;
    assign row_wrap  = (HW'(prow_reg) + HW'(1)) >= h;
    assign wcol_wrap = (FW'(wcol_reg) + FW'(1)) >= d;
    assign wrow_wrap = (FW'(wrow_reg) + FW'(1)) >= d;
    assign rrow_wrap = (FW'(rrow_reg) + FW'(1)) >= d;

    assign blk_valid  = accept && col_fit && row_fit;
    assign blk_addr   = bcol_reg;
    assign blk_sample = SW'(red_sample) +
                        (colour_reg ? (SW'(green_sample) + SW'(blue_sample)) : SW'(0));

    assign blk_info.first      = (wcol_reg == '0) && (wrow_reg == '0);
    assign blk_info.last       = ((FW'(wcol_reg) + FW'(1)) == d) &&
                                 ((FW'(wrow_reg) + FW'(1)) == d);
    assign blk_info.frame_last = col_final && row_final;
    assign blk_info.col        = boxavg_pkg::COORD_W'(bcol_reg);
    assign blk_info.row        = boxavg_pkg::COORD_W'(brow_reg);

    assign dd        = (2*FW)'(d) * (2*FW)'(d);
    assign div_next  = colour_reg ? DIV_W'(dd * boxavg_pkg::PLANES) : DIV_W'(dd);
    assign div_value = div_reg;

    // One restoring step of pixel row / factor, row bits taken from the top.
    assign factor_write = cfg_write &&
                          (boxavg_pkg::cfg_reg_t'(cfg_index) == boxavg_pkg::REG_FACTOR);
    assign row_partial  = {rrow_reg, prow_reg[row_bit_reg]};
    assign row_take     = row_partial >= PW'(d);
    assign row_rem      = row_take ? OW'(row_partial - PW'(d)) : OW'(row_partial);
    assign row_busy     = row_busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg <= boxavg_pkg::FACTOR_RESET;
            width_reg  <= boxavg_pkg::WIDTH_RESET;
            height_reg <= boxavg_pkg::HEIGHT_RESET;
            colour_reg <= 1'b0;
            div_reg    <= DIV_W'(boxavg_pkg::FACTOR_RESET * boxavg_pkg::FACTOR_RESET);
        end
        else
        begin
            div_reg <= div_next;
            if (cfg_write)
            begin
                unique case (boxavg_pkg::cfg_reg_t'(cfg_index))
                    boxavg_pkg::REG_FACTOR:
                        factor_reg <= cfg_data[boxavg_pkg::FACTOR_REG_W-1:0];
                    boxavg_pkg::REG_WIDTH:
                        width_reg <= cfg_data[boxavg_pkg::SIZE_REG_W-1:0];
                    boxavg_pkg::REG_HEIGHT:
                        height_reg <= cfg_data[boxavg_pkg::SIZE_REG_W-1:0];
                    boxavg_pkg::REG_COLOUR:
                        colour_reg <= cfg_data[0];
                    default:
                        colour_reg <= colour_reg;
                endcase
            end
        end
    end

    // Advance the raster position on every accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcol_reg <= '0;
            prow_reg <= '0;
            wcol_reg <= '0;
            wrow_reg <= '0;
            bcol_reg <= '0;
        end
        else if (accept)
        begin
            if (col_wrap)
            begin
                pcol_reg <= '0;
                wcol_reg <= '0;
                bcol_reg <= '0;
                if (row_wrap)
                begin
                    prow_reg <= '0;
                    wrow_reg <= '0;
                end
                else
                begin
                    prow_reg <= prow_reg + RW'(1);
                    if (wrow_wrap)
                    begin
                        wrow_reg <= '0;
                    end
                    else
                    begin
                        wrow_reg <= wrow_reg + OW'(1);
                    end
                end
            end
            else
            begin
                pcol_reg <= pcol_reg + AW'(1);
                if (wcol_wrap)
                begin
                    wcol_reg <= '0;
                    bcol_reg <= bcol_reg + AW'(1);
                end
                else
                begin
                    wcol_reg <= wcol_reg + OW'(1);
                end
            end
        end
    end

    // Track block row = pixel row / factor. A factor write rebuilds it one
    // quotient bit per cycle; hold the input until that is done.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brow_reg     <= '0;
            rrow_reg     <= '0;
            row_busy_reg <= 1'b0;
            row_bit_reg  <= '0;
        end
        else if (factor_write)
        begin
            brow_reg     <= '0;
            rrow_reg     <= '0;
            row_busy_reg <= 1'b1;
            row_bit_reg  <= CW'(RW - 1);
        end
        else if (row_busy_reg)
        begin
            brow_reg <= {brow_reg[RW-2:0], row_take};
            rrow_reg <= row_rem;
            if (row_bit_reg == '0)
            begin
                row_busy_reg <= 1'b0;
            end
            else
            begin
                row_bit_reg <= row_bit_reg - CW'(1);
            end
        end
        else if (accept && col_wrap)
        begin
            if (row_wrap)
            begin
                brow_reg <= '0;
                rrow_reg <= '0;
            end
            else if (rrow_wrap)
            begin
                rrow_reg <= '0;
                brow_reg <= brow_reg + RW'(1);
            end
            else
            begin
                rrow_reg <= rrow_reg + OW'(1);
            end
        end
    end

endmodule

// File: design/boxavg_accum.sv
// Column accumulator stage: read-modify-write of the per-block-column sums.
// Depends on boxavg_pkg and boxavg_ram.
module boxavg_accum #(
    parameter int MAX_WIDTH   = 4096,
    parameter int SAMPLE_BITS = 16,
    parameter int ACC_W       = 26
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            blk_valid,
    input  logic [$clog2(MAX_WIDTH)-1:0]    blk_addr,
    input  logic [SAMPLE_BITS+1:0]          blk_sample,
    input  boxavg_pkg::blk_info_t           blk_info,
    output logic                            ready,
    output logic                            sum_valid,
    output logic [ACC_W-1:0]                sum_value,
    output boxavg_pkg::blk_info_t           sum_info,
    input  logic                            sum_ready
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic [AW-1:0]         s1_addr_reg;
    logic [SAMPLE_BITS+1:0] s1_sample_reg;
    boxavg_pkg::blk_info_t s1_info_reg;
    logic                  fwd_hit_reg;
    logic [ACC_W-1:0]      fwd_data_reg;

    logic [ACC_W-1:0] rd_data;
    logic [ACC_W-1:0] base;
    logic [ACC_W-1:0] acc;
    logic             s1_go;

    boxavg_ram #(
        .DATA_W (ACC_W),
        .DEPTH  (MAX_WIDTH)
    ) u_sums (
        .clk   (clk),
        .we    (s1_go),
        .waddr (s1_addr_reg),
        .wdata (acc),
        .re    (blk_valid),
        .raddr (blk_addr),
        .rdata (rd_data)
    );

    // The write that lands in the same cycle as this beat's read is not seen
    // by the RAM output, so take it from the bypass register instead.
    always_comb
    begin
        if (s1_info_reg.first)
        begin
            base = '0;
        end
        else if (fwd_hit_reg)
        begin
            base = fwd_data_reg;
        end
        else
        begin
            base = rd_data;
        end
    end

    assign acc   = base + ACC_W'(s1_sample_reg);
    assign s1_go = s1_valid_reg && (!s1_info_reg.last || sum_ready);
    assign ready = !s1_valid_reg || s1_go;

    assign sum_valid = s1_go && s1_info_reg.last;
    assign sum_value = acc;
    assign sum_info  = s1_info_reg;

    assign s1_valid_next = blk_valid || (s1_valid_reg && !s1_go);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (blk_valid)
            begin
                fwd_hit_reg <= s1_go && (s1_addr_reg == blk_addr);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (blk_valid)
        begin
            s1_addr_reg   <= blk_addr;
            s1_sample_reg <= blk_sample;
            s1_info_reg   <= blk_info;
            fwd_data_reg  <= acc;
        end
    end

endmodule

// File: design/boxavg_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on boxavg_pkg.
module boxavg_div #(
    parameter int SAMPLE_BITS = 16,
    parameter int ACC_W       = 26,
    parameter int DIV_W       = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [ACC_W-1:0]           in_value,
    input  boxavg_pkg::blk_info_t      in_info,
    input  logic [DIV_W-1:0]           divisor,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [SAMPLE_BITS-1:0]     quotient,
    output boxavg_pkg::blk_info_t      out_info
);

    localparam int SB = SAMPLE_BITS;
    localparam int EW = ACC_W + DIV_W;

    logic                  v_reg    [SB];
    logic [ACC_W-1:0]      rem_reg  [SB];
    logic [SB-1:0]         q_reg    [SB];
    boxavg_pkg::blk_info_t info_reg [SB];
    logic                  rdy      [SB+1];

    assign rdy[SB]   = out_ready;
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[SB-1];
    assign quotient  = q_reg[SB-1];
    assign out_info  = info_reg[SB-1];

    for (genvar j = 0; j < SB; j++)
    begin : g_stage
        logic                  v_in;
        logic [ACC_W-1:0]      rem_in;
        logic [SB-1:0]         q_in;
        boxavg_pkg::blk_info_t info_in;
        logic [EW-1:0]         shifted;
        logic                  take;

        if (j == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = in_value;
            assign q_in    = '0;
            assign info_in = in_info;
        end
        else
        begin : g_next
            assign v_in    = v_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign q_in    = q_reg[j-1];
            assign info_in = info_reg[j-1];
        end

        // Stage j decides quotient bit SB-1-j.
        assign shifted = EW'(divisor) << (SB - 1 - j);
        assign take    = EW'(rem_in) >= shifted;
        assign rdy[j]  = !v_reg[j] || rdy[j+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (rdy[j])
            begin
                v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[j] && v_in)
            begin
                rem_reg[j]  <= take ? ACC_W'(EW'(rem_in) - shifted) : rem_in;
                q_reg[j]    <= {q_in[SB-2:0], take};
                info_reg[j] <= info_in;
            end
        end
    end

endmodule

// File: sim/block_mean_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the box-average downsampler: predicts every block mean from
// the accepted pixel beats and checks the result beats in order.
// Depends on boxavg_pkg.
module block_mean_checker #(
    parameter int MAX_WIDTH   = 4096,
    parameter int MAX_FACTOR  = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [boxavg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [boxavg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic [SAMPLE_BITS-1:0]             red_sample,
    input  logic [SAMPLE_BITS-1:0]             green_sample,
    input  logic [SAMPLE_BITS-1:0]             blue_sample,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic [SAMPLE_BITS-1:0]             average_sample,
    input  logic [boxavg_pkg::COORD_W-1:0]     out_column,
    input  logic [boxavg_pkg::COORD_W-1:0]     out_row,
    input  logic                               frame_last,
    output int                                 mismatches,
    output int                                 outstanding,
    output int                                 means_checked
);

    localparam int REPORT_LIMIT = 30;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0]         mean;
        logic [boxavg_pkg::COORD_W-1:0] col;
        logic [boxavg_pkg::COORD_W-1:0] row;
        logic                           last;
    } block_mean_t;

    logic [boxavg_pkg::FACTOR_REG_W-1:0] factor_reg;
    logic [boxavg_pkg::SIZE_REG_W-1:0]   width_reg;
    logic [boxavg_pkg::SIZE_REG_W-1:0]   height_reg;
    logic                                colour_reg;

    int unsigned tile_sums [MAX_WIDTH];
    int unsigned col_pos;
    int unsigned row_pos;
    int unsigned sub_col;
    int unsigned sub_row;
    int unsigned tile_col;

    block_mean_t expected_means [$];

    function automatic int unsigned limit_to(input int unsigned v, input int unsigned hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    task automatic absorb_pixel(input logic [SAMPLE_BITS-1:0] r, g, b);
        int unsigned d;
        int unsigned w;
        int unsigned h;
        int unsigned planes;
        int unsigned across;
        int unsigned down;
        int unsigned tile_row;
        int unsigned sample;
        int unsigned acc;
        block_mean_t m;
        d        = limit_to(factor_reg, MAX_FACTOR);
        w        = limit_to(width_reg, MAX_WIDTH);
        h        = limit_to(height_reg, boxavg_pkg::MAX_HEIGHT);
        planes   = colour_reg ? boxavg_pkg::PLANES : 1;
        across   = w / d;
        down     = h / d;
        tile_row = row_pos / d;
        sample   = r;
        if (colour_reg)
            sample = sample + g + b;

        // partial blocks at the right and bottom edges are dropped
        if (tile_col < across && tile_row < down)
        begin
            if (sub_col == 0 && sub_row == 0)
                acc = sample;
            else
                acc = tile_sums[tile_col] + sample;
            tile_sums[tile_col] = acc;
            if (sub_col == d - 1 && sub_row == d - 1)
            begin
                m.mean = SAMPLE_BITS'(acc / (d * d * planes));
                m.col  = tile_col[boxavg_pkg::COORD_W-1:0];
                m.row  = tile_row[boxavg_pkg::COORD_W-1:0];
                m.last = (tile_col == across - 1) && (tile_row == down - 1);
                expected_means.push_back(m);
            end
        end

        // advance the raster position; wrap at row and frame ends
        if (col_pos + 1 >= w)
        begin
            col_pos  = 0;
            sub_col  = 0;
            tile_col = 0;
            if (row_pos + 1 >= h)
            begin
                row_pos = 0;
                sub_row = 0;
            end
            else
            begin
                row_pos = row_pos + 1;
                sub_row = (sub_row + 1 >= d) ? 0 : sub_row + 1;
            end
        end
        else
        begin
            col_pos = col_pos + 1;
            if (sub_col + 1 >= d)
            begin
                sub_col  = 0;
                tile_col = (tile_col + 1) & 32'hFFF;
            end
            else
            begin
                sub_col = sub_col + 1;
            end
        end
    endtask

    task automatic compare_field(input string field, input int unsigned want, got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    task automatic compare_mean(input block_mean_t got);
        block_mean_t want;
        if (expected_means.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: unexpected beat, expected none, actual mean %0d col %0d row %0d last %0b",
                         $time, got.mean, got.col, got.row, got.last);
        end
        else
        begin
            want = expected_means.pop_front();
            compare_field("average_sample", want.mean, got.mean);
            compare_field("out_column", want.col, got.col);
            compare_field("out_row", want.row, got.row);
            compare_field("frame_last", want.last, got.last);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg  = boxavg_pkg::FACTOR_RESET;
            width_reg   = boxavg_pkg::WIDTH_RESET;
            height_reg  = boxavg_pkg::HEIGHT_RESET;
            colour_reg  = 1'b0;
            col_pos     = 0;
            row_pos     = 0;
            sub_col     = 0;
            sub_row     = 0;
            tile_col    = 0;
            expected_means.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (boxavg_pkg::cfg_reg_t'(cfg_index))
                    boxavg_pkg::REG_FACTOR: factor_reg = cfg_data[boxavg_pkg::FACTOR_REG_W-1:0];
                    boxavg_pkg::REG_WIDTH:  width_reg  = cfg_data[boxavg_pkg::SIZE_REG_W-1:0];
                    boxavg_pkg::REG_HEIGHT: height_reg = cfg_data[boxavg_pkg::SIZE_REG_W-1:0];
                    boxavg_pkg::REG_COLOUR: colour_reg = cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                absorb_pixel(red_sample, green_sample, blue_sample);
            if (out_valid && !out_stall)
            begin
                means_checked++;
                compare_mean({average_sample, out_column, out_row, frame_last});
            end
            outstanding = expected_means.size();
        end
    end

endmodule

// File: sim/box_average_downsampler_test.sv
`timescale 1ns / 1ps
// Testbench top for box_average_downsampler: clock, reset, register writes,
// pixel stimulus, output back-pressure and the verdict.
// Depends on boxavg_pkg, box_average_downsampler and block_mean_checker.
module box_average_downsampler_test;

    localparam int SAMPLE_BITS   = 16;
    localparam int SETTLE_CYCLES = 24;     // divider depth plus margin
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_PIXELS   = 300;
    localparam int RANDOM_PIXELS = 800;
    localparam int MAX_SIZE      = 4096;
    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;

    typedef enum int {PIX_RANDOM, PIX_ZERO, PIX_FULL} pixel_pattern_t;

    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          cfg_write    = 1'b0;
    boxavg_pkg::cfg_reg_t          cfg_index    = boxavg_pkg::REG_FACTOR;
    logic [boxavg_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                          in_valid     = 1'b0;
    logic                          in_stall;
    logic [SAMPLE_BITS-1:0]        red_sample   = '0;
    logic [SAMPLE_BITS-1:0]        green_sample = '0;
    logic [SAMPLE_BITS-1:0]        blue_sample  = '0;
    logic                          out_valid;
    logic                          out_stall    = 1'b0;
    logic [SAMPLE_BITS-1:0]        average_sample;
    logic [boxavg_pkg::COORD_W-1:0] out_column;
    logic [boxavg_pkg::COORD_W-1:0] out_row;
    logic                          frame_last;

    int mismatches;
    int outstanding;
    int means_checked;

    bit sender_gaps     = 1'b0;
    bit receiver_stalls = 1'b0;
    bit hold_request    = 1'b0;
    bit hold_done       = 1'b0;
    int hold_left       = 0;
    int stall_left      = 0;
    int frame_pixels    = 0;
    int pixels_sent     = 0;
    int settings_used   = 0;

    box_average_downsampler dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .red_sample     (red_sample),
        .green_sample   (green_sample),
        .blue_sample    (blue_sample),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .average_sample (average_sample),
        .out_column     (out_column),
        .out_row        (out_row),
        .frame_last     (frame_last)
    );

    block_mean_checker scoreboard (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .red_sample     (red_sample),
        .green_sample   (green_sample),
        .blue_sample    (blue_sample),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .average_sample (average_sample),
        .out_column     (out_column),
        .out_row        (out_row),
        .frame_last     (frame_last),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .means_checked  (means_checked)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int random_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            return $urandom_range(1, 3);
        if (pick < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int clamp_size(input int v);
        if (v < 1)
            return 1;
        if (v > MAX_SIZE)
            return MAX_SIZE;
        return v;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] random_sample();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return FULL_SCALE;
        return SAMPLE_BITS'($urandom_range(0, 65535));
    endfunction

    // receiver back-pressure; one long hold when requested
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall = 1'b1;
            hold_left--;
        end
        else if (hold_request && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_stall = 1'b1;
        end
        else if (stall_left > 0)
        begin
            out_stall = 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall = 1'b0;
            if (receiver_stalls && $urandom_range(0, 4) == 0)
                stall_left = random_gap();
        end
    end

    task automatic write_reg(input boxavg_pkg::cfg_reg_t idx, input int value);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = value[boxavg_pkg::CFG_DATA_W-1:0];
    endtask

    // wait for the block to drain, then load all four registers
    task automatic set_geometry(input int factor, width, height, input bit colour);
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_reg(boxavg_pkg::REG_FACTOR, factor);
        write_reg(boxavg_pkg::REG_WIDTH, width);
        write_reg(boxavg_pkg::REG_HEIGHT, height);
        write_reg(boxavg_pkg::REG_COLOUR, colour);
        @(negedge clk);
        cfg_write    = 1'b0;
        frame_pixels = clamp_size(width) * clamp_size(height);
        settings_used++;
    endtask

    task automatic send_pixels(input int count, input pixel_pattern_t pattern);
        int gap;
        for (int i = 0; i < count; i++)
        begin
            gap = (sender_gaps && $urandom_range(0, 3) == 0) ? random_gap() : 0;
            @(negedge clk);
            if (gap > 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid = 1'b1;
            case (pattern)
                PIX_ZERO:
                begin
                    red_sample   = '0;
                    green_sample = '0;
                    blue_sample  = '0;
                end
                PIX_FULL:
                begin
                    red_sample   = FULL_SCALE;
                    green_sample = FULL_SCALE;
                    blue_sample  = FULL_SCALE;
                end
                default:
                begin
                    red_sample   = random_sample();
                    green_sample = random_sample();
                    blue_sample  = random_sample();
                end
            endcase
            // hold the beat until it is taken
            do
                @(posedge clk);
            while (in_stall);
            pixels_sent++;
        end
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic run_frames(input int factor, width, height, input bit colour,
                              input int frames, input pixel_pattern_t pattern);
        set_geometry(factor, width, height, colour);
        send_pixels(frames * frame_pixels, pattern);
    endtask

    initial
    begin
        int pick;
        int d;
        int w;
        int h;
        int frames;
        int random_start;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero factor and sizes act as one: every pixel is its own block
        run_frames(0, 0, 0, 1'b0, 2, PIX_ZERO);
        run_frames(2, 4, 2, 1'b1, 1, PIX_FULL);
        // image smaller than one block: nothing comes out
        run_frames(3, 2, 2, 1'b0, 1, PIX_RANDOM);
        // change factor and mode at a block-row boundary in mid-frame
        set_geometry(1, 2, 4, 1'b0);
        send_pixels(4, PIX_RANDOM);
        set_geometry(2, 2, 4, 1'b1);
        send_pixels(4, PIX_RANDOM);

        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        // oversized factor clamps to the maximum; largest possible sum
        run_frames(31, 16, 16, 1'b1, 1, PIX_FULL);
        // oversized width clamps; long output hold fills the block
        set_geometry(1, 8191, 1, 1'b0);
        hold_request = 1'b1;
        send_pixels(HOLD_PIXELS, PIX_RANDOM);
        // one pixel on a 1 x 1 image returns the counters to the frame start
        set_geometry(1, 1, 1, 1'b0);
        send_pixels(1, PIX_RANDOM);

        random_start = pixels_sent;
        while (pixels_sent < random_start + RANDOM_PIXELS)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                d = 0;
                w = $urandom_range(0, 12);
                h = $urandom_range(0, 8);
            end
            else if (pick == 1)
            begin
                d = $urandom_range(16, 31);
                w = $urandom_range(16, 34);
                h = $urandom_range(15, 17);
            end
            else
            begin
                d = $urandom_range(1, 6);
                w = $urandom_range(0, 24);
                h = $urandom_range(0, 16);
            end
            frames = $urandom_range(1, 3);
            if (clamp_size(w) * clamp_size(h) * frames > 600)
                frames = 1;
            sender_gaps     = $urandom_range(0, 3) != 0;
            receiver_stalls = $urandom_range(0, 3) != 0;
            run_frames(d, w, h, 1'($urandom_range(0, 1)), frames, PIX_RANDOM);
        end

        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Sent %0d pixels under %0d register settings, checked %0d block means.",
                 pixels_sent, settings_used, means_checked);
        $display("Covered zero and oversized settings, mono and colour means, mid-frame reload, long hold.");
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #24_000_000;
        $display("Timed out with %0d block means still outstanding.", outstanding);
        $display("TEST FAILED");
        $finish;
    end

endmodule
